/* rtl/core/v3alu_pkg.sv */
// Shared definitions for the three-component Q16.16 vector unit.
// Operation codes and default word geometry; no dependencies.
`timescale 1ns / 1ps

package v3alu_pkg;

   localparam int V3_WORD_BITS = 32;
   localparam int V3_FRAC_BITS = 16;

   typedef enum logic [3:0] {
      FN_ADD    = 4'd0,
      FN_SUB    = 4'd1,
      FN_SCALE  = 4'd2,
      FN_NEG    = 4'd3,
      FN_DOT    = 4'd4,
      FN_CROSS  = 4'd5,
      FN_LEN    = 4'd6,
      FN_COS    = 4'd7,
      FN_NORM   = 4'd8
   } func_type;

endpackage

/* rtl/core/vector3_fixed_point_alu_unit.sv */
// Top level of the three-component fixed-point vector unit.
// Depends on v3alu_pkg (operation codes, default word geometry).
`timescale 1ns / 1ps

//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------------
//  request   | req_func, req_a_*, req_b_*, req_scale_k | start & !busy at clock edge
//  response  | rsp_r_*, rsp_scalar_out, rsp_flag       | rsp_valid, one cycle, no stall
//
//  The default geometry is Q16.16. A request may enter every cycle while busy is low;
//  the pipe depth is set by the one-bit-per-stage square root (WORD_BITS stages) and
//  the restoring divider (FRAC_BITS + 3 quotient bits, one per stage). busy is high
//  only while reset is asserted. Reset clears the valid bits of every stage; data
//  registers are not reset. The receiver cannot stall, so responses leave
//  strictly in request order, one per request.

module vector3_fixed_point_alu_unit #(
   parameter int WORD_BITS = v3alu_pkg::V3_WORD_BITS,
   parameter int FRAC_BITS = v3alu_pkg::V3_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [3:0]                  req_func,
   input  logic signed [WORD_BITS-1:0] req_a_x,
   input  logic signed [WORD_BITS-1:0] req_a_y,
   input  logic signed [WORD_BITS-1:0] req_a_z,
   input  logic signed [WORD_BITS-1:0] req_b_x,
   input  logic signed [WORD_BITS-1:0] req_b_y,
   input  logic signed [WORD_BITS-1:0] req_b_z,
   input  logic signed [WORD_BITS-1:0] req_scale_k,
   output logic                        rsp_valid,
   output logic signed [WORD_BITS-1:0] rsp_r_x,
   output logic signed [WORD_BITS-1:0] rsp_r_y,
   output logic signed [WORD_BITS-1:0] rsp_r_z,
   output logic signed [WORD_BITS-1:0] rsp_scalar_out,
   output logic                        rsp_flag
);
   import v3alu_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;          // full product / sum of squares
   localparam int SW = 2 * W + F + 4;  // wide signed working value
   localparam int QB = F + 3;          // quotient bits; |quotient| < 2^(F+2)
   localparam int DW = 2 * W + QB;     // divider remainder width
   localparam int RW = PW + 1;         // square-root remainder width
   localparam int LATENCY = 3 + W + 1 + QB + 1;

   localparam logic [SW-1:0] LOW_MASK = {{(SW-F){1'b0}}, {F{1'b1}}};

   // one request as it travels down the pipe
   typedef struct packed {
      logic              vld;
      logic [3:0]        fn;
      logic              za;
      logic              zb;
      logic [2:0][SW-1:0] v;
      logic [SW-1:0]     sc;
   } item_type;

   function automatic logic signed [SW-1:0] sxw(input logic signed [W-1:0] x);
      return {{(SW-W){x[W-1]}}, x};
   endfunction

   function automatic logic signed [SW-1:0] sxp(input logic signed [PW-1:0] x);
      return {{(SW-PW){x[PW-1]}}, x};
   endfunction

   // shift right by F, rounding toward zero
   function automatic logic signed [SW-1:0] trunc_f(input logic signed [SW-1:0] x);
      logic signed [SW-1:0] t;
      t = x + (x[SW-1] ? LOW_MASK : '0);
      return t >>> F;
   endfunction

   function automatic logic [SW-1:0] abs_f(input logic signed [SW-1:0] x);
      return x[SW-1] ? -x : x;
   endfunction

   // {overflow, saturated word}
   function automatic logic [W:0] sat_f(input logic signed [SW-1:0] x);
      logic ovf;
      logic [W-1:0] val;
      ovf = !((&x[SW-1:W-1]) || !(|x[SW-1:W-1]));
      if (ovf) begin
         val = x[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         val = x[W-1:0];
      end
      return {ovf, val};
   endfunction

   assign busy = reset;

   // ---------------- stage 0: capture ----------------
   logic                 vld0_ff;
   logic [3:0]           fn0_ff;
   logic signed [W-1:0]  a0_ff [3];
   logic signed [W-1:0]  b0_ff [3];
   logic signed [W-1:0]  k0_ff;

   always_ff @(posedge clock) begin
      vld0_ff  <= reset ? 1'b0 : start;
      fn0_ff   <= req_func;
      a0_ff[0] <= req_a_x;
      a0_ff[1] <= req_a_y;
      a0_ff[2] <= req_a_z;
      b0_ff[0] <= req_b_x;
      b0_ff[1] <= req_b_y;
      b0_ff[2] <= req_b_z;
      k0_ff    <= req_scale_k;
   end

   // ---------------- stage 1: nine multipliers ----------------
   logic signed [W-1:0]  ma [9];
   logic signed [W-1:0]  mb [9];
   logic signed [PW-1:0] p1_in [9];
   logic signed [PW-1:0] p1_ff [9];
   item_type             it1_in, it1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ma[i]   = a0_ff[i];
         mb[i]   = (fn0_ff == FN_SCALE) ? k0_ff : b0_ff[i];
         ma[i+3] = a0_ff[i];
         mb[i+3] = a0_ff[i];
         ma[i+6] = b0_ff[i];
         mb[i+6] = b0_ff[i];
      end
      if (fn0_ff == FN_CROSS) begin
         ma[3] = a0_ff[1]; mb[3] = b0_ff[2];
         ma[4] = b0_ff[1]; mb[4] = a0_ff[2];
         ma[5] = b0_ff[0]; mb[5] = a0_ff[2];
         ma[6] = a0_ff[0]; mb[6] = b0_ff[2];
         ma[7] = a0_ff[0]; mb[7] = b0_ff[1];
         ma[8] = b0_ff[0]; mb[8] = a0_ff[1];
      end
      for (int i = 0; i < 9; i++) begin
         p1_in[i] = ma[i] * mb[i];
      end

      it1_in.vld = vld0_ff && !reset;
      it1_in.fn  = fn0_ff;
      it1_in.za  = (a0_ff[0] == '0) && (a0_ff[1] == '0) && (a0_ff[2] == '0);
      it1_in.zb  = (b0_ff[0] == '0) && (b0_ff[1] == '0) && (b0_ff[2] == '0);
      it1_in.sc  = '0;
      for (int i = 0; i < 3; i++) begin
         case (fn0_ff)
            FN_ADD:  it1_in.v[i] = sxw(a0_ff[i]) + sxw(b0_ff[i]);
            FN_SUB:  it1_in.v[i] = sxw(a0_ff[i]) - sxw(b0_ff[i]);
            FN_NEG:  it1_in.v[i] = -sxw(a0_ff[i]);
            FN_NORM: it1_in.v[i] = sxw(a0_ff[i]);
            default: it1_in.v[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      it1_ff <= it1_in;
   end

   // ---------------- stage 2: sums and differences ----------------
   item_type             it2_in;
   logic [PW-1:0]        na_in, nb_in;

   // square-root pipe registers, index 0 loaded from stage 2
   item_type             itq_ff [W+1];
   logic [RW-1:0]        ra_ff  [W+1];
   logic [RW-1:0]        rb_ff  [W+1];
   logic [W-1:0]         qa_ff  [W+1];
   logic [W-1:0]         qb_ff  [W+1];

   always_comb begin
      it2_in = it1_ff;
      it2_in.vld = it1_ff.vld && !reset;
      case (it1_ff.fn)
         FN_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               it2_in.v[i] = sxp(p1_ff[i]);
            end
         end
         FN_CROSS: begin
            it2_in.v[0] = sxp(p1_ff[3]) - sxp(p1_ff[4]);
            it2_in.v[1] = sxp(p1_ff[5]) - sxp(p1_ff[6]);
            it2_in.v[2] = sxp(p1_ff[7]) - sxp(p1_ff[8]);
         end
         FN_DOT, FN_COS: begin
            it2_in.sc = sxp(p1_ff[0]) + sxp(p1_ff[1]) + sxp(p1_ff[2]);
         end
         default: ;
      endcase
      // squares are non-negative and three of them fit in PW bits
      na_in = $unsigned(p1_ff[3]) + $unsigned(p1_ff[4]) + $unsigned(p1_ff[5]);
      nb_in = $unsigned(p1_ff[6]) + $unsigned(p1_ff[7]) + $unsigned(p1_ff[8]);
   end

   // ---------------- square root: one root bit per stage ----------------
   item_type             itq_in [W];
   logic [RW-1:0]        ra_in  [W];
   logic [RW-1:0]        rb_in  [W];
   logic [W-1:0]         qa_in  [W];
   logic [W-1:0]         qb_in  [W];

   always_comb begin
      logic [RW-1:0] ta, tb;
      for (int k = 0; k < W; k++) begin
         // bit W-1-k; test = 2*q*2^j + 2^(2j)
         ta = (RW'(qa_ff[k]) << (W - k)) + (RW'(1) << (2 * (W - 1 - k)));
         tb = (RW'(qb_ff[k]) << (W - k)) + (RW'(1) << (2 * (W - 1 - k)));
         itq_in[k] = itq_ff[k];
         itq_in[k].vld = itq_ff[k].vld && !reset;
         if (ra_ff[k] >= ta) begin
            ra_in[k] = ra_ff[k] - ta;
            qa_in[k] = qa_ff[k] | (W'(1) << (W - 1 - k));
         end else begin
            ra_in[k] = ra_ff[k];
            qa_in[k] = qa_ff[k];
         end
         if (rb_ff[k] >= tb) begin
            rb_in[k] = rb_ff[k] - tb;
            qb_in[k] = qb_ff[k] | (W'(1) << (W - 1 - k));
         end else begin
            rb_in[k] = rb_ff[k];
            qb_in[k] = qb_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      itq_ff[0] <= it2_in;
      ra_ff[0]  <= RW'(na_in);
      rb_ff[0]  <= RW'(nb_in);
      qa_ff[0]  <= '0;
      qb_ff[0]  <= '0;
      for (int k = 0; k < W; k++) begin
         itq_ff[k+1] <= itq_in[k];
         ra_ff[k+1]  <= ra_in[k];
         rb_ff[k+1]  <= rb_in[k];
         qa_ff[k+1]  <= qa_in[k];
         qb_ff[k+1]  <= qb_in[k];
      end
   end

   // ---------------- denominator, numerators, truncation ----------------
   item_type             itd_in;
   logic [PW-1:0]        den_in;
   logic [DW-1:0]        num_in [3];
   logic [2:0]           ngv_in;

   item_type             itv_ff  [QB+1];
   logic [DW-1:0]        rem_ff  [QB+1][3];
   logic [QB-1:0]        quo_ff  [QB+1][3];
   logic [PW-1:0]        den_ff  [QB+1];
   logic [2:0]           ngv_ff  [QB+1];

   always_comb begin
      logic [SW-1:0] src, mag;
      itd_in = itq_ff[W];
      itd_in.vld = itq_ff[W].vld && !reset;
      if (itq_ff[W].fn == FN_COS) begin
         den_in = qa_ff[W] * qb_ff[W];
      end else begin
         den_in = PW'(qa_ff[W]);
      end
      for (int l = 0; l < 3; l++) begin
         src = (l == 0 && itq_ff[W].fn == FN_COS) ? itq_ff[W].sc : itq_ff[W].v[l];
         mag = abs_f(src);
         num_in[l] = {mag[DW-F-1:0], {F{1'b0}}};
         ngv_in[l] = src[SW-1];
      end
      case (itq_ff[W].fn)
         FN_SCALE, FN_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               itd_in.v[i] = trunc_f(itq_ff[W].v[i]);
            end
         end
         FN_DOT:  itd_in.sc = trunc_f(itq_ff[W].sc);
         FN_LEN:  itd_in.sc = SW'(qa_ff[W]);
         default: ;
      endcase
   end

   // ---------------- restoring divider: one quotient bit per stage ----------------
   item_type             itv_in [QB];
   logic [DW-1:0]        rem_in [QB][3];
   logic [QB-1:0]        quo_in [QB][3];

   always_comb begin
      logic [DW-1:0] dsh;
      for (int m = 0; m < QB; m++) begin
         itv_in[m] = itv_ff[m];
         itv_in[m].vld = itv_ff[m].vld && !reset;
         dsh = DW'(den_ff[m]) << (QB - 1 - m);
         for (int l = 0; l < 3; l++) begin
            if (rem_ff[m][l] >= dsh) begin
               rem_in[m][l] = rem_ff[m][l] - dsh;
               quo_in[m][l] = quo_ff[m][l] | (QB'(1) << (QB - 1 - m));
            end else begin
               rem_in[m][l] = rem_ff[m][l];
               quo_in[m][l] = quo_ff[m][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      itv_ff[0] <= itd_in;
      den_ff[0] <= den_in;
      ngv_ff[0] <= ngv_in;
      for (int l = 0; l < 3; l++) begin
         rem_ff[0][l] <= num_in[l];
         quo_ff[0][l] <= '0;
      end
      for (int m = 0; m < QB; m++) begin
         itv_ff[m+1] <= itv_in[m];
         den_ff[m+1] <= den_ff[m];
         ngv_ff[m+1] <= ngv_ff[m];
         for (int l = 0; l < 3; l++) begin
            rem_ff[m+1][l] <= rem_in[m][l];
            quo_ff[m+1][l] <= quo_in[m][l];
         end
      end
   end

   // ---------------- result select and saturation ----------------
   logic                 vld_o_ff;
   logic [W-1:0]         rx_ff, ry_ff, rz_ff, rs_ff;
   logic                 flag_ff;
   logic [W-1:0]         r_in [3];
   logic [W-1:0]         rs_in;
   logic                 flag_in;

   always_comb begin
      logic signed [SW-1:0] qs [3];
      logic [W:0] sv [3];
      logic [W:0] ss;
      item_type it;
      it = itv_ff[QB];
      for (int l = 0; l < 3; l++) begin
         qs[l] = ngv_ff[QB][l] ? -SW'(quo_ff[QB][l]) : SW'(quo_ff[QB][l]);
      end
      for (int i = 0; i < 3; i++) begin
         r_in[i] = '0;
         sv[i]   = sat_f((it.fn == FN_NORM) ? qs[i] : it.v[i]);
      end
      ss      = sat_f((it.fn == FN_COS) ? qs[0] : it.sc);
      rs_in   = '0;
      flag_in = 1'b0;
      case (it.fn)
         FN_ADD, FN_SUB, FN_SCALE, FN_NEG, FN_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               r_in[i] = sv[i][W-1:0];
            end
            flag_in = sv[0][W] | sv[1][W] | sv[2][W];
         end
         FN_NORM: begin
            if (it.za) begin
               flag_in = 1'b1;   // zero vector passes through as zero
            end else begin
               for (int i = 0; i < 3; i++) begin
                  r_in[i] = sv[i][W-1:0];
               end
               flag_in = sv[0][W] | sv[1][W] | sv[2][W];
            end
         end
         FN_DOT, FN_LEN: begin
            rs_in   = ss[W-1:0];
            flag_in = ss[W];
         end
         FN_COS: begin
            if (it.za || it.zb) begin
               flag_in = 1'b1;
            end else begin
               rs_in   = ss[W-1:0];
               flag_in = ss[W];
            end
         end
         default: flag_in = 1'b1;   // unassigned operation code
      endcase
   end

   always_ff @(posedge clock) begin
      vld_o_ff <= reset ? 1'b0 : itv_ff[QB].vld;
      rx_ff    <= r_in[0];
      ry_ff    <= r_in[1];
      rz_ff    <= r_in[2];
      rs_ff    <= rs_in;
      flag_ff  <= flag_in;
   end

   assign rsp_valid      = vld_o_ff;
   assign rsp_r_x        = rx_ff;
   assign rsp_r_y        = ry_ff;
   assign rsp_r_z        = rz_ff;
   assign rsp_scalar_out = rs_ff;
   assign rsp_flag       = flag_ff;

endmodule

/* rtl/core/v3alu_chk.sv */
// Port-level checker for the vector unit, with its bind statement.
// Depends on v3alu_pkg and vector3_fixed_point_alu_unit.
`timescale 1ns / 1ps

module v3alu_chk #(
   parameter int WORD_BITS = v3alu_pkg::V3_WORD_BITS,
   parameter int LAT       = 56
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [3:0]           req_func,
   input logic                 rsp_valid,
   input logic [WORD_BITS-1:0] rsp_scalar_out,
   input logic                 rsp_flag
);
   import v3alu_pkg::*;

   // every request comes back after the fixed latency
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("request without response");

   // no response appears without a request
   a_orig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without request");

   // unassigned codes always report the flag
   a_bad: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func > FN_NORM) |-> ##LAT rsp_flag)
      else $error("unassigned code without flag");

   // length is never negative
   a_len: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FN_LEN) |-> ##LAT !rsp_scalar_out[WORD_BITS-1])
      else $error("negative length");

   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind vector3_fixed_point_alu_unit v3alu_chk #(
   .WORD_BITS(WORD_BITS),
   .LAT(LATENCY)
) u_v3alu_chk (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_func(req_func),
   .rsp_valid(rsp_valid),
   .rsp_scalar_out(rsp_scalar_out),
   .rsp_flag(rsp_flag)
);

/* tb/sv/tb.sv */
// Self-checking bench for the three-component Q16.16 vector unit.
// Depends on v3alu_pkg and vector3_fixed_point_alu_unit; predicts each response in-bench.
`timescale 1ns / 1ps

module tb;
   import v3alu_pkg::*;

   localparam int WB = V3_WORD_BITS;
   localparam int FB = V3_FRAC_BITS;
   localparam int PIPE_LAT = 3 + WB + 1 + (FB + 3) + 1;
   localparam int IDLE_LIMIT = 20000;

   // Wide signed math: 32x32 products summed stay far inside 192 bits.
   typedef logic signed [191:0] wide_type;
   typedef logic signed [WB-1:0] word_type;

   typedef struct {
      word_type rx, ry, rz, sc;
      logic  fl;
   } vec_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_func = '0;
   word_type req_a_x = '0, req_a_y = '0, req_a_z = '0;
   word_type req_b_x = '0, req_b_y = '0, req_b_z = '0;
   word_type req_scale_k = '0;
   logic  rsp_valid;
   word_type rsp_r_x, rsp_r_y, rsp_r_z, rsp_scalar_out;
   logic  rsp_flag;

   vec_result_type expected_q[$];
   int err_cnt = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   vector3_fixed_point_alu_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .req_scale_k(req_scale_k),
      .rsp_valid(rsp_valid),
      .rsp_r_x(rsp_r_x), .rsp_r_y(rsp_r_y), .rsp_r_z(rsp_r_z),
      .rsp_scalar_out(rsp_scalar_out), .rsp_flag(rsp_flag)
   );

   // ---------------- predictor ----------------
   // truncate toward zero by FB fraction bits
   function automatic wide_type trunc_frac(wide_type v);
      if (v < 0) return -((-v) >>> FB);
      return v >>> FB;
   endfunction

   // quotient toward zero, zero on zero divisor
   function automatic wide_type div_tz(wide_type n, wide_type d);
      wide_type q;
      if (d == 0) return '0;
      q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   // floor square root of a non-negative value, bitwise
   function automatic wide_type floor_sqrt(wide_type n);
      wide_type res, b, t;
      res = '0;
      b = wide_type'(1) <<< 188;
      while (b != 0 && b > n) b = b >>> 2;
      while (b != 0) begin
         t = res + b;
         if (n >= t) begin
            n = n - t;
            res = (res >>> 1) + b;
         end else begin
            res = res >>> 1;
         end
         b = b >>> 2;
      end
      return res;
   endfunction

   function automatic word_type clamp_word(wide_type v, ref logic fl);
      wide_type mx, mn;
      mx = (wide_type'(1) <<< (WB - 1)) - 1;
      mn = -(wide_type'(1) <<< (WB - 1));
      if (v > mx) begin fl = 1'b1; return word_type'(mx); end
      if (v < mn) begin fl = 1'b1; return word_type'(mn); end
      return word_type'(v);
   endfunction

   function automatic vec_result_type compute_vec_op(logic [3:0] fn, word_type ax, word_type ay,
         word_type az, word_type bx, word_type by, word_type bz, word_type k);
      vec_result_type r;
      wide_type a[3], b[3], v[3], kk, len, den, dt;
      logic fl;
      a[0] = ax; a[1] = ay; a[2] = az;
      b[0] = bx; b[1] = by; b[2] = bz;
      kk = k;
      fl = 1'b0;
      r = '{default: '0};
      v[0] = 0; v[1] = 0; v[2] = 0;
      dt = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
      case (fn)
         FN_ADD, FN_SUB, FN_SCALE, FN_NEG, FN_CROSS, FN_NORM: begin
            if (fn == FN_NORM && a[0] == 0 && a[1] == 0 && a[2] == 0) begin
               fl = 1'b1;
            end else if (fn == FN_CROSS) begin
               v[0] = trunc_frac(a[1]*b[2] - b[1]*a[2]);
               v[1] = trunc_frac(b[0]*a[2] - a[0]*b[2]);
               v[2] = trunc_frac(a[0]*b[1] - b[0]*a[1]);
            end else begin
               len = floor_sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
               for (int i = 0; i < 3; i++) begin
                  case (fn)
                     FN_ADD:   v[i] = a[i] + b[i];
                     FN_SUB:   v[i] = a[i] - b[i];
                     FN_SCALE: v[i] = trunc_frac(a[i] * kk);
                     FN_NEG:   v[i] = -a[i];
                     default:  v[i] = div_tz(a[i] <<< FB, len);
                  endcase
               end
            end
            r.rx = clamp_word(v[0], fl);
            r.ry = clamp_word(v[1], fl);
            r.rz = clamp_word(v[2], fl);
         end
         FN_DOT: r.sc = clamp_word(trunc_frac(dt), fl);
         FN_LEN: r.sc = clamp_word(floor_sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]), fl);
         FN_COS: begin
            if ((a[0] == 0 && a[1] == 0 && a[2] == 0) ||
                (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
               fl = 1'b1;
            end else begin
               den = floor_sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]) *
                     floor_sqrt(b[0]*b[0] + b[1]*b[1] + b[2]*b[2]);
               r.sc = clamp_word(div_tz(dt <<< FB, den), fl);
            end
         end
         default: fl = 1'b1;   // undefined codes: zero fields, flag raised
      endcase
      r.fl = fl;
      return r;
   endfunction

   // ---------------- response checker ----------------
   always @(posedge clock) begin
      vec_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response x=%h y=%h z=%h s=%h f=%b", $time,
                     rsp_r_x, rsp_r_y, rsp_r_z, rsp_scalar_out, rsp_flag);
            err_cnt++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_r_x !== e.rx) begin
               $display("%0t: r_x exp %h got %h", $time, e.rx, rsp_r_x); err_cnt++;
            end
            if (rsp_r_y !== e.ry) begin
               $display("%0t: r_y exp %h got %h", $time, e.ry, rsp_r_y); err_cnt++;
            end
            if (rsp_r_z !== e.rz) begin
               $display("%0t: r_z exp %h got %h", $time, e.rz, rsp_r_z); err_cnt++;
            end
            if (rsp_scalar_out !== e.sc) begin
               $display("%0t: scalar exp %h got %h", $time, e.sc, rsp_scalar_out);
               err_cnt++;
            end
            if (rsp_flag !== e.fl) begin
               $display("%0t: flag exp %b got %b", $time, e.fl, rsp_flag); err_cnt++;
            end
         end
      end
   end

   // Watchdog: cycles with neither a request nor a response accepted.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   int burst_left = 0;

   // Sends one request; start stays high across back-to-back requests.
   task automatic send_request(logic [3:0] fn, word_type ax, word_type ay, word_type az,
         word_type bx, word_type by, word_type bz, word_type k);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_func <= fn;
      req_a_x <= ax; req_a_y <= ay; req_a_z <= az;
      req_b_x <= bx; req_b_y <= by; req_b_z <= bz;
      req_scale_k <= k;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.push_back(compute_vec_op(fn, ax, ay, az, bx, by, bz, k));
   endtask

   task automatic stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Random word: mostly small Q16.16 values, sometimes full range or extremes.
   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0:       return word_type'($urandom());
         1:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         2:       return '0;
         3, 4:    return word_type'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
         default: return word_type'($signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000);
      endcase
   endfunction

   task automatic test_directed_extremes();
      word_type mx, mn, one;
      mx = 32'sh7FFFFFFF; mn = 32'sh80000000; one = 32'sh00010000;
      send_request(FN_ADD, mx, mn, one, one, mn, mx, 0);     // positive & negative saturation
      send_request(FN_SUB, mn, mx, 0, one, mn, 0, 0);
      send_request(FN_SCALE, mx, mn, one, 0, 0, 0, mn);
      send_request(FN_SCALE, one, -one, 3 * one, 0, 0, 0, 32'sh00008000);
      send_request(FN_NEG, mn, mx, -one, 0, 0, 0, 0);        // -min saturates
      send_request(FN_DOT, mx, mx, mx, mx, mx, mx, 0);
      send_request(FN_DOT, -one, 2 * one, 7, one, one, -3, 0);
      send_request(FN_CROSS, one, 0, 0, 0, one, 0, 0);
      send_request(FN_CROSS, mx, mn, mx, mn, mx, mn, 0);
      send_request(FN_LEN, mx, mx, mx, 0, 0, 0, 0);
      send_request(FN_LEN, 3 * one, 4 * one, 0, 0, 0, 0, 0);
      send_request(FN_COS, 0, 0, 0, one, one, one, 0);       // zero A
      send_request(FN_COS, one, 0, 0, 0, 0, 0, 0);           // zero B
      send_request(FN_COS, one, one, 0, -one, 2 * one, 5, 0);
      send_request(FN_COS, 1, 0, 0, 1, 0, 0, 0);             // smallest nonzero lengths
      send_request(FN_NORM, 0, 0, 0, one, one, one, one);    // zero-length normalize
      send_request(FN_NORM, 3 * one, -4 * one, 0, 0, 0, 0, 0);
      send_request(FN_NORM, 1, 0, 0, 0, 0, 0, 0);
      for (int c = 9; c < 16; c++) send_request(4'(c), one, one, one, one, one, one, one);
      stop_sending();
   endtask

   task automatic drain_responses();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_random_ops(int n);
      logic [3:0] fn;
      word_type av[3];
      for (int i = 0; i < n; i++) begin
         fn = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
         for (int j = 0; j < 3; j++) av[j] = rand_word();
         // occasionally a zero vector to hit the cosine/normalize special cases
         if ($urandom_range(0, 15) == 0) av = '{0, 0, 0};
         send_request(fn, av[0], av[1], av[2],
                      ($urandom_range(0, 20) == 0) ? word_type'(0) : rand_word(),
                      rand_word(), rand_word(), rand_word());
      end
      stop_sending();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      drain_responses();          // sender holds off until the pipe is empty
      test_random_ops(1000);
      drain_responses();
      test_random_ops(925);
      drain_responses();
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (err_cnt == 0 && expected_q.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
